@@ src/order_table_best_price_core_defines.svh @@
// Assertion macros for the order table block
`ifndef ORDER_TABLE_BEST_PRICE_CORE_DEFINES_SVH
`define ORDER_TABLE_BEST_PRICE_CORE_DEFINES_SVH

// clocked check, off during reset
`define OTBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check, also live during reset
`define OTBP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/otbp_pkg.sv @@
// ----------------------------------------------------------------------------
// otbp_pkg
// Shared constants, codes and control types of the order table block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package otbp_pkg;
	localparam int ENTRIES = 16;
	localparam int SLOT_W  = $clog2(ENTRIES);
	localparam int RANK_W  = SLOT_W;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_FIND   = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan_step;
		logic fin;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
	} dp_stat_t;
endpackage
`default_nettype wire

@@ src/otbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// otbp_ctrl
// Sequencer: accept, execute, scan all slots, finish, present the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "order_table_best_price_core_defines.svh"
module otbp_ctrl import otbp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	`OTBP_ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid), "ready while a word is pending")
	`OTBP_ASSERT(a_hold_out, out_valid && !out_ready |=> out_valid, "result dropped under stall")
	`OTBP_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted twice")
endmodule
`default_nettype wire

@@ src/otbp_datapath.sv @@
// ----------------------------------------------------------------------------
// otbp_datapath
// Entry store, age ranks, slot scan for count, min, max and match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module otbp_datapath import otbp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctrl_cmd_t          cmd,
	output dp_stat_t                stat,
	input  wire logic [1:0]         in_cmd,
	input  wire logic [3:0]         in_slot,
	input  wire logic [15:0]        in_quantity,
	input  wire logic [7:0]         in_trader,
	input  wire logic [7:0]         in_item,
	input  wire logic signed [31:0] in_price,
	input  wire logic               in_side,
	output logic [1:0]              status,
	output logic [3:0]              result_slot,
	output logic [15:0]             found_quantity,
	output logic [7:0]              found_trader,
	output logic [7:0]              found_item,
	output logic signed [31:0]      found_price,
	output logic                    found_side,
	output logic [4:0]              entry_count,
	output logic [3:0]              min_slot,
	output logic [3:0]              max_slot,
	output logic signed [31:0]      lowest_price,
	output logic signed [31:0]      highest_price
);
	logic [ENTRIES-1:0]      valid_q;
	logic [RANK_W-1:0]       rank_q [ENTRIES];
	logic [15:0]             qty_q [ENTRIES];
	logic [7:0]              trader_q [ENTRIES];
	logic [7:0]              item_q [ENTRIES];
	logic signed [31:0]      price_q [ENTRIES];
	logic                    side_q [ENTRIES];

	// latched input word
	logic [1:0]              cmd_q;
	logic [3:0]              slot_q;
	logic [15:0]             key_q;
	logic [7:0]              trader_in_q, item_in_q;
	logic signed [31:0]      price_in_q;
	logic                    side_in_q;

	logic [1:0]              st_q;
	logic [SLOT_W-1:0]       rslot_q;

	logic [SLOT_W-1:0]       idx_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    mn_v_q, mx_v_q, f_v_q;
	logic [SLOT_W-1:0]       mn_slot_q, mx_slot_q, f_slot_q;
	logic [RANK_W-1:0]       mn_rank_q, mx_rank_q, f_rank_q;
	logic signed [31:0]      mn_price_q, mx_price_q, f_price_q;
	logic [15:0]             f_qty_q;
	logic [7:0]              f_trader_q, f_item_q;
	logic                    f_side_q;

	logic                    free_found;
	logic [SLOT_W-1:0]       free_idx;
	logic [SLOT_W-1:0]       del_idx;
	logic                    del_ok;
	logic [RANK_W-1:0]       del_rank;
	logic                    do_ins, do_del;

	logic                    sv;
	logic signed [31:0]      sp;
	logic [RANK_W-1:0]       sr;
	logic                    take_mn, take_mx, take_f;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign del_idx  = SLOT_W'(slot_q);
	assign del_ok   = (32'(slot_q) < ENTRIES) && valid_q[del_idx];
	assign del_rank = rank_q[del_idx];
	assign do_ins   = cmd.exec && (cmd_q == CMD_INSERT) && free_found;
	assign do_del   = cmd.exec && (cmd_q == CMD_DELETE) && del_ok;

	assign sv = valid_q[idx_q];
	assign sp = price_q[idx_q];
	assign sr = rank_q[idx_q];
	// on equal prices the older (higher rank) entry wins
	assign take_mn = sv && (!mn_v_q || sp < mn_price_q || (sp == mn_price_q && sr > mn_rank_q));
	assign take_mx = sv && (!mx_v_q || sp > mx_price_q || (sp == mx_price_q && sr > mx_rank_q));
	assign take_f  = sv && (cmd_q == CMD_FIND) && (qty_q[idx_q] == key_q)
		&& (!f_v_q || sr < f_rank_q);

	assign stat.scan_last = (idx_q == SLOT_W'(ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			mn_v_q  <= 1'b0;
			mx_v_q  <= 1'b0;
			f_v_q   <= 1'b0;
		end else begin
			if (do_ins) valid_q[free_idx] <= 1'b1;
			if (do_del) valid_q[del_idx] <= 1'b0;
			if (cmd.exec) begin
				idx_q  <= '0;
				cnt_q  <= '0;
				mn_v_q <= 1'b0;
				mx_v_q <= 1'b0;
				f_v_q  <= 1'b0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (sv) cnt_q <= cnt_q + 1'b1;
				if (take_mn) mn_v_q <= 1'b1;
				if (take_mx) mx_v_q <= 1'b1;
				if (take_f) f_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q       <= in_cmd;
			slot_q      <= in_slot;
			key_q       <= in_quantity;
			trader_in_q <= in_trader;
			item_in_q   <= in_item;
			price_in_q  <= in_price;
			side_in_q   <= in_side;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (do_ins) begin
				if (SLOT_W'(i) == free_idx) rank_q[i] <= '0;
				else if (valid_q[i]) rank_q[i] <= rank_q[i] + 1'b1;
			end else if (do_del) begin
				if (valid_q[i] && rank_q[i] > del_rank) rank_q[i] <= rank_q[i] - 1'b1;
			end
		end
		if (do_ins) begin
			qty_q[free_idx]    <= key_q;
			trader_q[free_idx] <= trader_in_q;
			item_q[free_idx]   <= item_in_q;
			price_q[free_idx]  <= price_in_q;
			side_q[free_idx]   <= side_in_q;
		end
		if (cmd.exec) begin
			if (cmd_q == CMD_INSERT) begin
				st_q    <= free_found ? ST_DONE : ST_FULL;
				rslot_q <= free_found ? free_idx : '0;
			end else if (do_del) begin
				st_q    <= ST_DONE;
				rslot_q <= del_idx;
			end else begin
				st_q    <= ST_NOT_FOUND;
				rslot_q <= '0;
			end
		end
		if (cmd.scan_step) begin
			if (take_mn) begin
				mn_slot_q  <= idx_q;
				mn_rank_q  <= sr;
				mn_price_q <= sp;
			end
			if (take_mx) begin
				mx_slot_q  <= idx_q;
				mx_rank_q  <= sr;
				mx_price_q <= sp;
			end
			if (take_f) begin
				f_slot_q   <= idx_q;
				f_rank_q   <= sr;
				f_qty_q    <= qty_q[idx_q];
				f_trader_q <= trader_q[idx_q];
				f_item_q   <= item_q[idx_q];
				f_price_q  <= sp;
				f_side_q   <= side_q[idx_q];
			end
		end
		if (cmd.fin) begin
			if (cmd_q == CMD_FIND && f_v_q) begin
				status         <= ST_DONE;
				result_slot    <= 4'(f_slot_q);
				found_quantity <= f_qty_q;
				found_trader   <= f_trader_q;
				found_item     <= f_item_q;
				found_price    <= f_price_q;
				found_side     <= f_side_q;
			end else begin
				status         <= st_q;
				result_slot    <= 4'(rslot_q);
				found_quantity <= '0;
				found_trader   <= '0;
				found_item     <= '0;
				found_price    <= '0;
				found_side     <= 1'b0;
			end
			entry_count   <= 5'(cnt_q);
			min_slot      <= mn_v_q ? 4'(mn_slot_q) : 4'd0;
			max_slot      <= mx_v_q ? 4'(mx_slot_q) : 4'd0;
			lowest_price  <= mn_v_q ? mn_price_q : 32'sd0;
			highest_price <= mx_v_q ? mx_price_q : 32'sd0;
		end
	end
endmodule
`default_nettype wire

@@ src/order_table_best_price_core.sv @@
// ----------------------------------------------------------------------------
// order_table_best_price_core
// Order table of 16 entries with newest-match search and best-price report.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one command word (insert, delete
//   by slot, find by quantity). Output channel out_valid/out_ready returns one
//   result word per command, with entry count and min/max price slots.
//   One command is in flight at a time: accept, execute, scan of all ENTRIES
//   slots (one slot per cycle through a single compare unit), finish, then
//   the result is presented with out_valid. A new command is accepted only
//   after the receiver has taken the result of the last one.
//   While out_ready is low the result word holds and in_ready stays low.
//   Reset (arst_n low) empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module order_table_best_price_core import otbp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic [3:0]         slot,
	input  wire logic [15:0]        quantity,
	input  wire logic [7:0]         trader_id,
	input  wire logic [7:0]         item_id,
	input  wire logic signed [31:0] price,
	input  wire logic               side,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [3:0]              result_slot,
	output logic [15:0]             found_quantity,
	output logic [7:0]              found_trader,
	output logic [7:0]              found_item,
	output logic signed [31:0]      found_price,
	output logic                    found_side,
	output logic [4:0]              entry_count,
	output logic [3:0]              min_slot,
	output logic [3:0]              max_slot,
	output logic signed [31:0]      lowest_price,
	output logic signed [31:0]      highest_price
);
	ctrl_cmd_t ctl;
	dp_stat_t  dst;

	otbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (dst),
		.cmd       (ctl)
	);

	otbp_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl),
		.stat           (dst),
		.in_cmd         (cmd),
		.in_slot        (slot),
		.in_quantity    (quantity),
		.in_trader      (trader_id),
		.in_item        (item_id),
		.in_price       (price),
		.in_side        (side),
		.status         (status),
		.result_slot    (result_slot),
		.found_quantity (found_quantity),
		.found_trader   (found_trader),
		.found_item     (found_item),
		.found_price    (found_price),
		.found_side     (found_side),
		.entry_count    (entry_count),
		.min_slot       (min_slot),
		.max_slot       (max_slot),
		.lowest_price   (lowest_price),
		.highest_price  (highest_price)
	);
endmodule
`default_nettype wire
